// ===== design/vertex_dedup_indexer_assert.svh =====
// assertion macros for the vertex dedup indexer scan sequencer (vdi_ctrl)
`ifndef VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VDI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vdi_pkg.sv =====
// shared constants, types and float compare for the vertex dedup indexer
package vdi_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int OUT_IDX_W    = 10;
    localparam int FLT_W        = 32;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_HAS_TEXCOORDS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HAS_NORMALS   = 1'b1;

    localparam logic [FLT_W-2:0] EXP_ALL_ONES = 31'h7F80_0000;

    typedef logic [FLT_W-1:0] flt_t;

    typedef struct packed {
        flt_t norm_z;
        flt_t norm_y;
        flt_t norm_x;
        flt_t tex_v;
        flt_t tex_u;
        flt_t pos_z;
        flt_t pos_y;
        flt_t pos_x;
    } vertex_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } mem_req_t;

    // ieee single equality: nan never equal, +0 equals -0
    function automatic logic feq(flt_t a, flt_t b);
        logic [FLT_W-2:0] ma;
        logic [FLT_W-2:0] mb;
        ma = a[FLT_W-2:0];
        mb = b[FLT_W-2:0];
        if (ma > EXP_ALL_ONES || mb > EXP_ALL_ONES)
        begin
            return 1'b0;
        end
        if (ma == '0 && mb == '0)
        begin
            return 1'b1;
        end
        return a == b;
    endfunction

endpackage

// ===== design/vertex_dedup_indexer.sv =====
// Vertex dedup indexer: maps face corners to indices of unique vertices.
// Input stream (s_*): one word per face corner, eight float bit patterns in
// s_tdata and the start_new flag in s_tuser; start_new empties the table
// before the corner is looked up.
// Output stream (m_*): one word per corner with the vertex index, is_new and
// table_full. On a miss with a full table the index is 0 and table_full is 1.
// Config port: cfg_we writes cfg_wdata to register cfg_addr
// (0 = has_texcoords, 1 = has_normals); write only while no corner is in flight.
// A corner walks the stored vertices one per cycle through the table
// memory's single read port; a hit on an entry ends the walk early.
// One corner is handled at a time.
// Reset clears the fill count, both config flags go to 1 and the output goes
// idle; the table memory needs no clearing pass.
// When the receiver stalls, the result holds in the output register and the
// block still takes and processes the next corner, then waits to deliver it.
module vertex_dedup_indexer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [255:0]                    s_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
                                                       // norm_x, norm_y, norm_z
    input  logic                            s_tuser,   // start_new
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // vertex_index, zero pad
    output logic [1:0]                      m_tuser,   // is_new, table_full
    input  logic                            cfg_we,
    input  logic [vdi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic                            cfg_wdata
);

    logic                          has_tex_reg;
    logic                          has_norm_reg;
    vdi_pkg::vertex_t              in_vertex;
    vdi_pkg::vertex_t              key;
    vdi_pkg::mem_req_t             mem_req;
    logic                          entry_match;
    logic [vdi_pkg::OUT_IDX_W-1:0] out_index;
    logic                          out_is_new;
    logic                          out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_tex_reg  <= 1'b1;
            has_norm_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                vdi_pkg::CFG_HAS_TEXCOORDS: has_tex_reg  <= cfg_wdata;
                vdi_pkg::CFG_HAS_NORMALS:   has_norm_reg <= cfg_wdata;
                default:                    has_tex_reg  <= has_tex_reg;
            endcase
        end
    end

    assign in_vertex.pos_x  = s_tdata[31:0];
    assign in_vertex.pos_y  = s_tdata[63:32];
    assign in_vertex.pos_z  = s_tdata[95:64];
    assign in_vertex.tex_u  = s_tdata[127:96];
    assign in_vertex.tex_v  = s_tdata[159:128];
    assign in_vertex.norm_x = s_tdata[191:160];
    assign in_vertex.norm_y = s_tdata[223:192];
    assign in_vertex.norm_z = s_tdata[255:224];

    vdi_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .has_texcoords (has_tex_reg),
        .has_normals   (has_norm_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .start_new     (s_tuser),
        .in_vertex     (in_vertex),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_index     (out_index),
        .out_is_new    (out_is_new),
        .out_full      (out_full),
        .mem_req       (mem_req),
        .key           (key),
        .entry_match   (entry_match)
    );

    vdi_store u_store (
        .clk         (clk),
        .mem_req     (mem_req),
        .key         (key),
        .entry_match (entry_match)
    );

    assign m_tdata = {6'b0, out_index};
    assign m_tuser = {out_full, out_is_new};

endmodule

// ===== design/vdi_store.sv =====
// vertex table memory with registered read and entry compare
module vdi_store (
    input  logic               clk,
    input  vdi_pkg::mem_req_t  mem_req,
    input  vdi_pkg::vertex_t   key,
    output logic               entry_match
);

    vdi_pkg::vertex_t mem [vdi_pkg::MAX_VERTICES];
    vdi_pkg::vertex_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign entry_match = vdi_pkg::feq(rd_data_reg.pos_x,  key.pos_x)
                       & vdi_pkg::feq(rd_data_reg.pos_y,  key.pos_y)
                       & vdi_pkg::feq(rd_data_reg.pos_z,  key.pos_z)
                       & vdi_pkg::feq(rd_data_reg.tex_u,  key.tex_u)
                       & vdi_pkg::feq(rd_data_reg.tex_v,  key.tex_v)
                       & vdi_pkg::feq(rd_data_reg.norm_x, key.norm_x)
                       & vdi_pkg::feq(rd_data_reg.norm_y, key.norm_y)
                       & vdi_pkg::feq(rd_data_reg.norm_z, key.norm_z);

endmodule

// ===== design/vdi_ctrl.sv =====
// scan sequencer: key capture, table walk, append and result register
`include "vertex_dedup_indexer_assert.svh"

module vdi_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             has_texcoords,
    input  logic                             has_normals,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             start_new,
    input  vdi_pkg::vertex_t                 in_vertex,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [vdi_pkg::OUT_IDX_W-1:0]    out_index,
    output logic                             out_is_new,
    output logic                             out_full,
    output vdi_pkg::mem_req_t                mem_req,
    output vdi_pkg::vertex_t                 key,
    input  logic                             entry_match
);

    vdi_pkg::state_t                  state_reg, state_next;
    logic [vdi_pkg::CNT_W-1:0]        fill_reg, fill_next;
    logic [vdi_pkg::CNT_W-1:0]        scan_addr_reg, scan_addr_next;
    logic                             pend_reg, pend_next;
    logic [vdi_pkg::IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                             out_valid_reg, out_valid_next;
    logic [vdi_pkg::OUT_IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic                             out_new_reg, out_new_next;
    logic                             out_full_reg, out_full_next;
    logic [vdi_pkg::OUT_IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic                             res_new_reg, res_new_next;
    logic                             res_full_reg, res_full_next;
    vdi_pkg::vertex_t                 key_reg, key_next;

    logic issue;
    logic match;
    logic scan_end;
    logic out_free;

    assign issue    = scan_addr_reg < fill_reg;
    assign match    = pend_reg && entry_match;
    assign scan_end = !issue && !pend_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vdi_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vdi_pkg::S_SCAN;
                end
            end
            vdi_pkg::S_SCAN:
            begin
                if (match || scan_end)
                begin
                    state_next = vdi_pkg::S_RESULT;
                end
            end
            vdi_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = vdi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vdi_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_full_next  = res_full_reg;
        key_next       = key_reg;
        mem_req        = '0;
        unique case (state_reg)
            vdi_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next = in_vertex;
                    if (!has_texcoords)
                    begin
                        key_next.tex_u = '0;
                        key_next.tex_v = '0;
                    end
                    if (!has_normals)
                    begin
                        key_next.norm_x = '0;
                        key_next.norm_y = '0;
                        key_next.norm_z = '0;
                    end
                    if (start_new)
                    begin
                        fill_next = '0;
                    end
                    scan_addr_next = '0;
                    pend_next      = 1'b0;
                end
            end
            vdi_pkg::S_SCAN:
            begin
                if (match)
                begin
                    res_idx_next  = vdi_pkg::OUT_IDX_W'(pend_idx_reg);
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    pend_next     = 1'b0;
                end
                else if (scan_end)
                begin
                    if (fill_reg < vdi_pkg::CNT_W'(vdi_pkg::MAX_VERTICES))
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = fill_reg[vdi_pkg::IDX_W-1:0];
                        res_idx_next    = vdi_pkg::OUT_IDX_W'(fill_reg);
                        res_new_next    = 1'b1;
                        res_full_next   = 1'b0;
                        fill_next       = fill_reg + vdi_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_full_next = 1'b1;
                    end
                end
                else
                begin
                    // walk one entry a cycle, compare lands in the cycle after the read
                    mem_req.rd_en   = issue;
                    mem_req.rd_addr = scan_addr_reg[vdi_pkg::IDX_W-1:0];
                    pend_next       = issue;
                    pend_idx_next   = scan_addr_reg[vdi_pkg::IDX_W-1:0];
                    if (issue)
                    begin
                        scan_addr_next = scan_addr_reg + vdi_pkg::CNT_W'(1);
                    end
                end
            end
            vdi_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_new_next   = res_new_reg;
                    out_full_next  = res_full_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vdi_pkg::S_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        pend_idx_reg  <= pend_idx_next;
        out_idx_reg   <= out_idx_next;
        out_new_reg   <= out_new_next;
        out_full_reg  <= out_full_next;
        res_idx_reg   <= res_idx_next;
        res_new_reg   <= res_new_next;
        res_full_reg  <= res_full_next;
        key_reg       <= key_next;
    end

    assign in_ready   = state_reg == vdi_pkg::S_IDLE;
    assign out_valid  = out_valid_reg;
    assign out_index  = out_idx_reg;
    assign out_is_new = out_new_reg;
    assign out_full   = out_full_reg;
    assign key        = key_reg;

    `VDI_ASSERT_NOW(a_rd_below_fill, mem_req.rd_en,
        vdi_pkg::CNT_W'(mem_req.rd_addr) < fill_reg, "table read beyond fill count")
    `VDI_ASSERT_NOW(a_wr_has_room, mem_req.wr_en,
        fill_reg < vdi_pkg::CNT_W'(vdi_pkg::MAX_VERTICES), "append into a full table")
    `VDI_ASSERT_NOW(a_no_rd_wr_overlap, mem_req.wr_en, !mem_req.rd_en && !pend_reg,
        "append while a table read is in flight")
    `VDI_ASSERT_NEXT(a_append_grows, mem_req.wr_en,
        fill_reg == $past(fill_reg) + vdi_pkg::CNT_W'(1), "fill count not advanced on append")

endmodule

// ===== tb/sv/vdi_result_checker.sv =====
// result checker for the vertex dedup indexer: predicts each index word and compares it
module vdi_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [255:0]                   s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,
    input  logic [1:0]                     m_tuser,
    input  logic                           cfg_we,
    input  logic [vdi_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic                           cfg_wdata,
    output int                             mismatches,
    output int                             pending
);

    localparam int USER_IS_NEW = 0;
    localparam int USER_FULL   = 1;

    typedef struct packed {
        logic [vdi_pkg::OUT_IDX_W-1:0] index;
        logic                          is_new;
        logic                          full;
    } corner_result_t;

    vdi_pkg::vertex_t unique_vertices [vdi_pkg::MAX_VERTICES];
    int unsigned      vertex_count;
    logic             tex_on;
    logic             norm_on;
    corner_result_t   awaited_results [$];

    // nan equals nothing, the two zeros equal each other
    function automatic logic float_eq(vdi_pkg::flt_t a, vdi_pkg::flt_t b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        if (a_nan || b_nan)
            return 1'b0;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic logic same_vertex(vdi_pkg::vertex_t a, vdi_pkg::vertex_t b);
        return float_eq(a.pos_x, b.pos_x) && float_eq(a.pos_y, b.pos_y) &&
               float_eq(a.pos_z, b.pos_z) && float_eq(a.tex_u, b.tex_u) &&
               float_eq(a.tex_v, b.tex_v) && float_eq(a.norm_x, b.norm_x) &&
               float_eq(a.norm_y, b.norm_y) && float_eq(a.norm_z, b.norm_z);
    endfunction

    function automatic corner_result_t lookup_corner(logic start, vdi_pkg::vertex_t corner);
        corner_result_t res;
        int             i;
        res = '0;
        if (start)
            vertex_count = 0;
        if (!tex_on)
        begin
            corner.tex_u = '0;
            corner.tex_v = '0;
        end
        if (!norm_on)
        begin
            corner.norm_x = '0;
            corner.norm_y = '0;
            corner.norm_z = '0;
        end
        for (i = 0; i < vertex_count; i++)
        begin
            if (same_vertex(unique_vertices[i], corner))
            begin
                res.index = i[vdi_pkg::OUT_IDX_W-1:0];
                return res;
            end
        end
        if (vertex_count < vdi_pkg::MAX_VERTICES)
        begin
            unique_vertices[vertex_count] = corner;
            res.index  = vertex_count[vdi_pkg::OUT_IDX_W-1:0];
            res.is_new = 1'b1;
            vertex_count++;
        end
        else
        begin
            // no match and no room left
            res.full = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        corner_result_t want;
        if (!rst_n)
        begin
            vertex_count = 0;
            tex_on       = 1'b1;
            norm_on      = 1'b1;
            mismatches   = 0;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    vdi_pkg::CFG_HAS_TEXCOORDS: tex_on  = cfg_wdata;
                    vdi_pkg::CFG_HAS_NORMALS:   norm_on = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: index word with no corner waiting, got index %0d user %b",
                             $time, m_tdata[vdi_pkg::OUT_IDX_W-1:0], m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_tdata[vdi_pkg::OUT_IDX_W-1:0] !== want.index)
                    begin
                        $display("%0t: vertex_index mismatch, expected %0d, got %0d",
                                 $time, want.index, m_tdata[vdi_pkg::OUT_IDX_W-1:0]);
                        mismatches++;
                    end
                    if (m_tuser[USER_IS_NEW] !== want.is_new)
                    begin
                        $display("%0t: is_new mismatch, expected %b, got %b",
                                 $time, want.is_new, m_tuser[USER_IS_NEW]);
                        mismatches++;
                    end
                    if (m_tuser[USER_FULL] !== want.full)
                    begin
                        $display("%0t: table_full mismatch, expected %b, got %b",
                                 $time, want.full, m_tuser[USER_FULL]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(),
                                       lookup_corner(s_tuser, s_tdata));
        end
        pending = awaited_results.size();
    end

endmodule

// ===== tb/sv/tb_vertex_dedup_indexer.sv =====
// testbench top for the vertex dedup indexer: stimulus, handshake pacing and verdict
module tb_vertex_dedup_indexer;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_CORNERS  = 95;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [255:0]                   s_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x,
                                               // norm_y, norm_z
    logic                           s_tuser;   // start_new
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;   // vertex_index, zero pad
    logic [1:0]                     m_tuser;   // is_new, table_full
    logic                           cfg_we;
    logic [vdi_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic                           cfg_wdata;

    int               mismatches;
    int               pending;
    int               stalled_cycles = 0;
    int               sink_hold;
    logic             no_idle;
    vdi_pkg::vertex_t recent [$];

    vertex_dedup_indexer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    vdi_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic vdi_pkg::flt_t pick_float();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h3F80_0000;
            3:       return 32'hBF80_0000;
            4:       return 32'h7FC0_0000;
            5:       return 32'hFFFF_FFFF;
            6:       return 32'h7F80_0000;
            7:       return 32'hFF80_0000;
            8:       return 32'h7F80_0001;
            9:       return 32'h0000_0001;
            10:      return 32'h7F7F_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // exponent top bit cleared, so never nan or infinity
    function automatic vdi_pkg::vertex_t plain_vertex();
        vdi_pkg::vertex_t v;
        int               k;
        for (k = 0; k < 8; k++)
            v[k*32 +: 32] = $urandom & 32'hBFFF_FFFF;
        return v;
    endfunction

    task automatic send_corner(input logic start, input vdi_pkg::vertex_t v);
        repeat (pick_gap()) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = start;
        s_tdata  = v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        // junk on the data lines while valid is low
        s_tvalid = 1'b0;
        s_tuser  = 1'($urandom_range(0, 1));
        s_tdata  = {8{$urandom}};
    endtask

    task automatic wait_results_done();
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_flags(input logic tex, input logic norm);
        wait_results_done();
        cfg_we    = 1'b1;
        cfg_addr  = vdi_pkg::CFG_HAS_TEXCOORDS;
        cfg_wdata = tex;
        @(negedge clk);
        cfg_addr  = vdi_pkg::CFG_HAS_NORMALS;
        cfg_wdata = norm;
        @(negedge clk);
        cfg_we    = 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** vertex_dedup_indexer: FAILED **");
            $finish;
        end
    end

    initial
    begin
        m_tready  = 1'b0;
        sink_hold = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready = 1'b0;
                sink_hold--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 2) == 0)
                    sink_hold = pick_gap();
            end
        end
    end

    initial
    begin
        vdi_pkg::vertex_t v;
        vdi_pkg::vertex_t a;
        logic             start;
        int               r;
        int               k;
        int               n;
        int               phase;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = vdi_pkg::CFG_HAS_TEXCOORDS;
        cfg_wdata = 1'b0;
        no_idle   = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zeros of both signs, nans, infinities, extremes
        send_corner(1'b1, {8{32'h0000_0000}});
        send_corner(1'b0, {8{32'h8000_0000}});
        send_corner(1'b0, {8{32'hFFFF_FFFF}});
        send_corner(1'b0, {8{32'hFFFF_FFFF}});
        send_corner(1'b0, {8{32'h7F80_0000}});
        send_corner(1'b0, {8{32'hFF80_0000}});
        send_corner(1'b0, {8{32'h7F80_0000}});
        send_corner(1'b0, {8{32'h7F7F_FFFF}});
        send_corner(1'b0, {8{32'h0000_0001}});
        send_corner(1'b0, {8{32'h7F80_0001}});
        send_corner(1'b0, {8{32'h7F80_0001}});
        send_corner(1'b0, {8{32'h0000_0000}});

        // one attribute off by a bit, then the exact repeat
        a = plain_vertex();
        send_corner(1'b0, a);
        v = a;
        v.tex_u[0] = ~v.tex_u[0];
        send_corner(1'b0, v);
        v = a;
        v.norm_z[0] = ~v.norm_z[0];
        send_corner(1'b0, v);
        send_corner(1'b0, a);
        send_corner(1'b1, a);

        // disabled attributes are stored as zero and ignored
        set_flags(1'b0, 1'b0);
        for (n = 0; n < 3; n++)
        begin
            v = a;
            for (k = 3; k < 8; k++)
                v[k*32 +: 32] = (n == 2) ? 32'h0 : $urandom;
            send_corner(1'b0, v);
        end
        set_flags(1'b1, 1'b0);
        v = a;
        v.norm_x = $urandom;
        send_corner(1'b0, v);
        send_corner(1'b0, a);
        set_flags(1'b0, 1'b1);
        v = a;
        v.tex_v = $urandom;
        send_corner(1'b0, v);
        send_corner(1'b0, a);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       set_flags(1'b1, 1'b1);
                1:       set_flags(1'b0, 1'b1);
                2:       set_flags(1'b1, 1'b0);
                3:       set_flags(1'b0, 1'b0);
                default: set_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            no_idle = (phase == 2);
            for (n = 0; n < PHASE_CORNERS; n++)
            begin
                start = (n == 0) || ($urandom_range(0, 29) == 0);
                if (start)
                    recent.delete();
                r = $urandom_range(0, 99);
                if (recent.size() > 0 && r < 45)
                begin
                    v = recent[$urandom_range(0, recent.size() - 1)];
                end
                else if (recent.size() > 0 && r < 70)
                begin
                    v = recent[$urandom_range(0, recent.size() - 1)];
                    k = $urandom_range(0, 7);
                    if ($urandom_range(0, 1) == 0)
                        v[k*32 + 31] = ~v[k*32 + 31];
                    else
                        v[k*32 +: 32] = pick_float();
                end
                else
                begin
                    for (k = 0; k < 8; k++)
                        v[k*32 +: 32] = pick_float();
                end
                if (recent.size() < 24)
                    recent.insert(recent.size(), v);
                if ($urandom_range(0, 79) == 0)
                    wait_results_done();
                send_corner(start, v);
            end
        end
        no_idle = 1'b0;

        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("** vertex_dedup_indexer: PASSED **");
        else
            $display("** vertex_dedup_indexer: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/vdi_pkg.sv
design/vdi_store.sv
design/vdi_ctrl.sv
design/vertex_dedup_indexer.sv
tb/sv/vdi_result_checker.sv
tb/sv/tb_vertex_dedup_indexer.sv
